// File: rtl/bsul_pkg.sv
// Package for the bounded sorted unique id list.
// Holds the command codes, register indexes, defaults and the cell control and status structs.
// No dependencies.
package bsul_pkg;

	localparam int DEF_MAX_ENTRIES = 32;
	localparam int ID_W = 32;
	localparam int IDX_W = 5;
	localparam logic [5:0] CAPACITY_RESET = 6'd32;

	typedef enum logic [1:0] {
		CMD_OFFER = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef enum logic {
		REG_LOWER_BOUND   = 1'b0,
		REG_LIST_CAPACITY = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic              commit;
		logic [ID_W-1:0]   ident;
		logic [IDX_W-1:0]  rd_index;
	} bsul_ctl_t;

	typedef struct packed {
		logic              eq;
		logic              open;
		logic [ID_W-1:0]   rd_data;
	} bsul_stat_t;

endpackage

// File: rtl/bsul_cell.sv
// One cell of the sorted list: holds a single entry and compares it against the offered id.
// Takes the neighbor's entry and less-than flag from the cell below. Depends on bsul_pkg.
module bsul_cell
	import bsul_pkg::*;
#(
	parameter int IDX = 0,
	parameter int CNT_W = 6
) (
	input  logic             clk,
	input  bsul_ctl_t        ctl,
	input  logic [CNT_W-1:0] held_count,
	input  logic [CNT_W-1:0] shift_limit,
	input  logic             prev_lt,
	input  logic [ID_W-1:0]  prev_entry,
	output logic             lt,
	output logic [ID_W-1:0]  entry,
	output bsul_stat_t       stat
);

	logic [ID_W-1:0] entry_q;
	logic            in_range;
	logic            in_limit;
	logic            at_pos;
	logic            shift;
	logic            rd_hit;

	assign in_range = CNT_W'(IDX) < held_count;
	assign in_limit = CNT_W'(IDX) <= shift_limit;
	assign lt       = in_range && (entry_q < ctl.ident);
	assign at_pos   = !lt && prev_lt;
	assign shift    = !lt && !prev_lt && in_limit;
	assign rd_hit   = in_range && ({{(32-IDX_W){1'b0}}, ctl.rd_index} == 32'(IDX));
	assign entry    = entry_q;

	assign stat.eq      = in_range && (entry_q == ctl.ident);
	assign stat.open    = at_pos && in_limit;
	assign stat.rd_data = rd_hit ? entry_q : '0;

	always_ff @(posedge clk) begin
		if (ctl.commit && (at_pos || shift)) begin
			entry_q <= at_pos ? ctl.ident : prev_entry;
		end
	end

endmodule

// File: rtl/bounded_sorted_unique_id_list_top.sv
// Top level of the bounded sorted unique id list: configuration, handshake and the cell row.
// Depends on bsul_pkg and bsul_cell.
//
// The block keeps up to MAX_ENTRIES distinct ids in ascending order in a row of cells.
// It takes one command word per clock cycle unless the output side stalls, and returns one
// registered result word for each; every cell compares its entry with the offered id in
// parallel and the row shifts up by one place in the same cycle, so each command is done
// at the edge that accepts it. A finished result waits in the output register while the
// next command is already taken, as long as the output side takes its word.
// Configuration writes are meant for idle periods; no reset pass is needed after reset.
module bounded_sorted_unique_id_list_top
	import bsul_pkg::*;
#(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // cmd[1:0], ident[33:2], read_index[38:34], zero[39]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // entry_value[31:0], entry_count[37:32], overflowed[38], stored[39]
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CAP_W = (CNT_W > 6) ? CNT_W : 6;

	logic [ID_W-1:0]  lower_bound_q;
	logic [5:0]       capacity_q;
	logic [CNT_W-1:0] held_count_q;
	logic             flag_q;
	logic             m_tvalid_q;
	logic [39:0]      m_tdata_q;

	logic [1:0]       cmd;
	logic [ID_W-1:0]  ident;
	logic [IDX_W-1:0] read_index;
	logic             accept;
	logic [CAP_W-1:0] cap_ext;
	logic [CAP_W-1:0] max_ext;
	logic [CNT_W-1:0] eff_cap;
	logic             full;
	logic [CNT_W-1:0] shift_limit;
	logic             offer;
	logic             dup;
	logic             fit;
	logic             commit;
	logic [ID_W-1:0]  rd_value;
	logic [CNT_W-1:0] count_next;
	logic             flag_next;
	logic [ID_W-1:0]  entry_value;
	bsul_ctl_t        ctl;

	logic [MAX_ENTRIES:0]  chain_lt;
	logic [ID_W-1:0]       chain_entry [MAX_ENTRIES+1];
	bsul_stat_t            stat [MAX_ENTRIES];

	assign cmd        = s_tdata[1:0];
	assign ident      = s_tdata[33:2];
	assign read_index = s_tdata[38:34];

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign cap_ext     = CAP_W'(capacity_q);
	assign max_ext     = CAP_W'(MAX_ENTRIES);
	assign eff_cap     = CNT_W'((cap_ext > max_ext) ? max_ext : cap_ext);
	assign full        = held_count_q >= eff_cap;
	assign shift_limit = full ? CNT_W'(eff_cap - CNT_W'(1)) : held_count_q;
	assign offer       = (cmd == CMD_OFFER) && (ident != '0) && (ident > lower_bound_q) &&
	                     (eff_cap != '0);
	assign commit      = accept && offer && !dup && fit;

	assign ctl.commit   = commit;
	assign ctl.ident    = ident;
	assign ctl.rd_index = read_index;

	assign chain_lt[0]    = 1'b1;
	assign chain_entry[0] = '0;

	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		bsul_cell #(
			.IDX   (g),
			.CNT_W (CNT_W)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.held_count  (held_count_q),
			.shift_limit (shift_limit),
			.prev_lt     (chain_lt[g]),
			.prev_entry  (chain_entry[g]),
			.lt          (chain_lt[g+1]),
			.entry       (chain_entry[g+1]),
			.stat        (stat[g])
		);
	end

	always_comb begin
		dup      = 1'b0;
		fit      = 1'b0;
		rd_value = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			dup      = dup | stat[i].eq;
			fit      = fit | stat[i].open;
			rd_value = rd_value | stat[i].rd_data;
		end
	end

	always_comb begin
		count_next  = held_count_q;
		flag_next   = flag_q;
		entry_value = '0;
		case (cmd)
			CMD_OFFER: begin
				if (offer && !dup) begin
					if (full) begin
						flag_next = 1'b1;
					end else begin
						count_next = held_count_q + CNT_W'(1);
					end
				end
			end
			CMD_READ: begin
				entry_value = rd_value;
			end
			CMD_CLEAR: begin
				count_next = '0;
				flag_next  = 1'b0;
			end
			default: begin
				entry_value = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_bound_q <= '0;
			capacity_q    <= CAPACITY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOWER_BOUND:   lower_bound_q <= cfg_data;
				REG_LIST_CAPACITY: capacity_q    <= cfg_data[5:0];
				default:           capacity_q    <= capacity_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= '0;
			flag_q       <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (accept) begin
				held_count_q <= count_next;
				flag_q       <= flag_next;
				m_tvalid_q   <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {commit, flag_next, 6'(count_next), entry_value};
		end
	end

endmodule

// File: sim/bounded_sorted_unique_id_list_top_tb.sv
// Self-checking testbench for bounded_sorted_unique_id_list_top: directed and random command words.
// Depends on bsul_pkg and the RTL top; expected words come from a behavioral list predictor.
// The stream sides idle and stall at random, and the registers are rewritten between phases.
module bounded_sorted_unique_id_list_top_tb;
	import bsul_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int LONG_HOLD = 100;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] ident;
		logic [4:0]  read_index;
	} list_command_t;

	typedef struct {
		logic [31:0] value;
		logic [5:0]  count;
		logic        overflowed;
		logic        stored;
	} list_result_t;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_style_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // cmd[1:0], ident[33:2], read_index[38:34], zero[39]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // entry_value[31:0], entry_count[37:32], overflowed[38], stored[39]
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;

	bounded_sorted_unique_id_list_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6ns clk = ~clk;

	// Predictor state and its copy of the registers.
	logic [31:0] list_cells [DEF_MAX_ENTRIES];
	int          held_count = 0;
	logic        truncated = 1'b0;
	logic [31:0] lower_bound_cfg = '0;
	logic [5:0]  capacity_cfg = CAPACITY_RESET;

	list_command_t pending_words [$];
	list_result_t  expected_results [$];
	list_command_t next_word;
	int            words_queued = 0;
	int            words_done = 0;
	int            mismatch_count = 0;
	bit            in_taken = 1'b0;
	bit            out_taken = 1'b0;
	int            burst_left = 0;
	int            gap_left = 0;
	int            hold_requests = 0;
	int            holds_done = 0;
	int            hold_count = 0;
	int            rx_segment = 0;
	rx_style_t     rx_style = RX_OPEN;
	int            cycle_count = 0;

	function automatic bit insert_ident(logic [31:0] id);
		int cap;
		int pos;
		cap = (capacity_cfg > DEF_MAX_ENTRIES) ? DEF_MAX_ENTRIES : int'(capacity_cfg);
		pos = 0;
		if (id == 0 || id <= lower_bound_cfg || cap == 0)
			return 1'b0;
		while (pos < held_count && pos < DEF_MAX_ENTRIES && list_cells[pos] < id)
			pos++;
		if (pos < held_count && pos < DEF_MAX_ENTRIES && list_cells[pos] == id)
			return 1'b0;
		if (held_count < cap) begin
			for (int i = held_count; i > pos; i--)
				list_cells[i] = list_cells[i-1];
			list_cells[pos] = id;
			held_count++;
			return 1'b1;
		end
		truncated = 1'b1;
		if (pos >= cap)
			return 1'b0;
		for (int i = cap - 1; i > pos; i--)
			list_cells[i] = list_cells[i-1];
		list_cells[pos] = id;
		return 1'b1;
	endfunction

	function automatic list_result_t apply_list_command(list_command_t w);
		list_result_t r;
		r.value = '0;
		r.stored = 1'b0;
		case (w.cmd)
			CMD_OFFER: begin
				r.stored = insert_ident(w.ident);
			end
			CMD_READ: begin
				if (w.read_index < held_count)
					r.value = list_cells[w.read_index];
			end
			CMD_CLEAR: begin
				held_count = 0;
				truncated = 1'b0;
			end
			default: begin
			end
		endcase
		r.count = 6'(held_count);
		r.overflowed = truncated;
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("%0t ns: mismatch on %s, got %h, expected %h", $time, field, got, want);
		mismatch_count++;
	endtask

	// Checks the result side first, then predicts the word taken at the same edge.
	always @(posedge clk) begin
		list_result_t want;
		cycle_count++;
		in_taken = arst_n && s_tvalid && s_tready;
		out_taken = arst_n && m_tvalid && m_tready;
		if (out_taken) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unpredicted word", m_tdata[31:0], '0);
			end else begin
				want = expected_results.pop_front();
				if (m_tdata[31:0] !== want.value)
					report_mismatch("entry_value", m_tdata[31:0], want.value);
				if (m_tdata[37:32] !== want.count)
					report_mismatch("entry_count", 32'(m_tdata[37:32]), 32'(want.count));
				if (m_tdata[38] !== want.overflowed)
					report_mismatch("overflowed", 32'(m_tdata[38]), 32'(want.overflowed));
				if (m_tdata[39] !== want.stored)
					report_mismatch("stored", 32'(m_tdata[39]), 32'(want.stored));
			end
		end
		if (in_taken) begin
			expected_results.push_back(apply_list_command(list_command_t'({s_tdata[1:0],
				s_tdata[33:2], s_tdata[38:34]})));
			words_done++;
		end
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (!s_tvalid || in_taken) begin
			if (gap_left > 0) begin
				s_tvalid <= 1'b0;
				gap_left--;
			end else if (pending_words.size() > 0) begin
				next_word = pending_words.pop_front();
				s_tdata <= {1'b0, next_word.read_index, next_word.ident, next_word.cmd};
				s_tvalid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (holds_done < hold_requests) begin
			m_tready <= 1'b0;
			if (hold_count == LONG_HOLD) begin
				holds_done++;
				hold_count = 0;
			end else begin
				hold_count++;
			end
		end else begin
			if (rx_segment == 0) begin
				rx_style = rx_style_t'($urandom_range(0, 3));
				rx_segment = $urandom_range(10, 60);
			end
			rx_segment--;
			case (rx_style)
				RX_OPEN:   m_tready <= 1'b1;
				RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
				RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
				default:   m_tready <= rx_segment[0];
			endcase
		end
	end

	task automatic queue_word(logic [1:0] cmd, logic [31:0] ident, logic [4:0] read_index);
		pending_words.push_back('{cmd: cmd, ident: ident, read_index: read_index});
		words_queued++;
	endtask

	task automatic wait_idle();
		while (words_done != words_queued || expected_results.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_register(reg_index_t index, logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (index == REG_LOWER_BOUND)
			lower_bound_cfg = value;
		else
			capacity_cfg = value[5:0];
	endtask

	function automatic logic [31:0] pick_ident(logic [31:0] lb);
		logic [32:0] near;
		int roll;
		roll = $urandom_range(0, 99);
		near = {1'b0, lb} + 33'($urandom_range(1, 48));
		if (roll < 55)
			return near[32] ? 32'hFFFF_FFFF - 32'($urandom_range(0, 15)) : near[31:0];
		if (roll < 63)
			return '0;
		if (roll < 73)
			return lb - 32'($urandom_range(0, 3));
		return $urandom;
	endfunction

	task automatic random_phase(logic [31:0] lb, logic [5:0] cap, int n_words,
			bit long_hold, bit pause_midway);
		int read_span;
		int roll;
		logic [1:0] op;
		logic [4:0] index;
		wait_idle();
		write_register(REG_LOWER_BOUND, lb);
		write_register(REG_LIST_CAPACITY, {26'd0, cap});
		read_span = (cap == 0 || cap > 32) ? 32 : int'(cap);
		if (long_hold)
			hold_requests++;
		for (int n = 0; n < n_words; n++) begin
			if (pause_midway && n == n_words / 2)
				wait_idle();
			roll = $urandom_range(0, 99);
			if (roll < 72)
				op = CMD_OFFER;
			else if (roll < 88 || roll >= 94)
				op = CMD_READ;
			else if (roll < 90)
				op = CMD_CLEAR;
			else
				op = CMD_UNUSED;
			if (roll >= 94 || $urandom_range(0, 2) == 0)
				index = 5'($urandom);
			else
				index = 5'($urandom_range(0, read_span - 1));
			queue_word(op, pick_ident(lb), index);
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: zero id, extremes, a duplicate, the unused command, reads past the end.
		queue_word(CMD_OFFER, 32'h0, 5'd0);
		queue_word(CMD_OFFER, 32'hFFFF_FFFF, 5'd0);
		queue_word(CMD_OFFER, 32'd5, 5'd0);
		queue_word(CMD_OFFER, 32'd5, 5'd0);
		queue_word(CMD_OFFER, 32'd3, 5'd0);
		queue_word(CMD_UNUSED, 32'd0, 5'd0);
		queue_word(CMD_READ, 32'd0, 5'd0);
		queue_word(CMD_READ, 32'd0, 5'd2);
		queue_word(CMD_READ, 32'd0, 5'd31);
		queue_word(CMD_CLEAR, 32'd0, 5'd0);
		queue_word(CMD_READ, 32'd0, 5'd0);

		// Full list of two: bound itself rejected, then two overflows that each displace the top entry.
		wait_idle();
		write_register(REG_LOWER_BOUND, 32'd10);
		write_register(REG_LIST_CAPACITY, 32'd2);
		queue_word(CMD_OFFER, 32'd10, 5'd0);
		queue_word(CMD_OFFER, 32'd11, 5'd0);
		queue_word(CMD_OFFER, 32'd40, 5'd0);
		queue_word(CMD_OFFER, 32'd30, 5'd0);
		queue_word(CMD_OFFER, 32'd12, 5'd0);
		queue_word(CMD_READ, 32'd0, 5'd1);

		// A capacity of zero ignores every offer.
		wait_idle();
		write_register(REG_LIST_CAPACITY, 32'd0);
		queue_word(CMD_OFFER, 32'd50, 5'd0);

		// Capacity lowered below the count: only the cells below it shift.
		wait_idle();
		write_register(REG_LOWER_BOUND, 32'd0);
		write_register(REG_LIST_CAPACITY, 32'd4);
		queue_word(CMD_OFFER, 32'd7, 5'd0);
		queue_word(CMD_OFFER, 32'd8, 5'd0);
		wait_idle();
		write_register(REG_LIST_CAPACITY, 32'd2);
		queue_word(CMD_OFFER, 32'd3, 5'd0);
		queue_word(CMD_READ, 32'd0, 5'd3);
		queue_word(CMD_READ, 32'd0, 5'd1);

		// Capacity above the cell count and a bound near the top of the id range.
		wait_idle();
		write_register(REG_LOWER_BOUND, 32'hFFFF_FFFE);
		write_register(REG_LIST_CAPACITY, 32'd63);
		queue_word(CMD_CLEAR, 32'd0, 5'd0);
		queue_word(CMD_OFFER, 32'hFFFF_FFFF, 5'd0);
		queue_word(CMD_OFFER, 32'hFFFF_FFFE, 5'd0);
		queue_word(CMD_READ, 32'd0, 5'd0);

		random_phase(32'd0, 6'd32, 70, 1'b1, 1'b0);
		random_phase(32'd0, 6'd1, 60, 1'b0, 1'b1);
		random_phase($urandom, 6'd7, 70, 1'b0, 1'b0);
		random_phase(32'hFFFF_FF80, 6'd32, 70, 1'b0, 1'b0);
		random_phase($urandom, 6'd63, 70, 1'b0, 1'b0);
		random_phase($urandom, 6'd0, 20, 1'b0, 1'b0);
		random_phase(32'd1000, 6'd3, 70, 1'b1, 1'b0);
		random_phase(32'hFFFF_FFFF, 6'd5, 15, 1'b0, 1'b0);
		random_phase($urandom, 6'($urandom_range(1, 32)), 70, 1'b0, 1'b0);
		random_phase(32'd0, 6'd33, 70, 1'b0, 1'b0);

		wait_idle();
		repeat (4) @(negedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
